@@ src/nfcd_pkg.sv @@
// Shared types and constants for the NFC response frame deframer.
// No dependencies; imported by every module of the block and by the checker.
`timescale 1ns / 1ps
`default_nettype none
package nfcd_pkg;

  // frame-end status codes
  localparam logic [3:0] STAT_OK        = 4'd0;
  localparam logic [3:0] STAT_PREAMBLE  = 4'd1;
  localparam logic [3:0] STAT_ERR_FRAME = 4'd2;
  localparam logic [3:0] STAT_LEN_CS    = 4'd3;
  localparam logic [3:0] STAT_DIR       = 4'd4;
  localparam logic [3:0] STAT_CMD       = 4'd5;
  localparam logic [3:0] STAT_DATA_CS   = 4'd6;
  localparam logic [3:0] STAT_POSTAMBLE = 4'd7;
  localparam logic [3:0] STAT_BAD_LEN   = 4'd8;

  // frame constants
  localparam logic [7:0] DIR_BYTE   = 8'hD5;
  localparam logic [7:0] PRE_ZERO   = 8'h00;
  localparam logic [7:0] PRE_START  = 8'hFF;
  localparam logic [7:0] ERR_LEN    = 8'h01;
  localparam logic [7:0] EXT_MARK   = 8'hFF;
  localparam logic [7:0] POST_BYTE  = 8'h00;
  localparam logic [8:0] LEN_CS_SUM = 9'd256;
  localparam logic [1:0] ERR_SKIP   = 2'd3;

  // one received byte request
  typedef struct packed {
    logic       frame_start;
    logic [7:0] rx_byte;
  } in_item_t;

  // one result request
  typedef struct packed {
    logic        data_valid;
    logic [7:0]  payload_byte;
    logic        frame_done;
    logic [3:0]  status;
    logic [15:0] payload_length;
  } res_t;

endpackage
`default_nettype wire

@@ src/nfcd_in_stage.sv @@
// Input register stage of the deframer: holds one received byte request.
// Depends on nfcd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nfcd_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire nfcd_pkg::in_item_t in_item,
  input  wire logic              pop,
  output logic                   item_vld,
  output nfcd_pkg::in_item_t     item
);
  import nfcd_pkg::*;

  logic     vld_r, vld_nxt;
  in_item_t item_r;
  logic     load;

  // stall only while a held byte cannot move on
  assign in_stall = vld_r && !pop;
  assign load     = in_valid && !in_stall;
  assign vld_nxt  = load || (vld_r && !pop);

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule
`default_nettype wire

@@ src/nfcd_parser.sv @@
// Frame parser: state registers and the per-byte next-state and result logic.
// Depends on nfcd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nfcd_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire nfcd_pkg::in_item_t item,
  input  wire logic [7:0]         exp_cmd,
  output logic                    has_res,
  output nfcd_pkg::res_t          res
);
  import nfcd_pkg::*;

  localparam logic [3:0] PH_PRE0    = 4'd0;
  localparam logic [3:0] PH_PRE1    = 4'd1;
  localparam logic [3:0] PH_PRE2    = 4'd2;
  localparam logic [3:0] PH_LEN     = 4'd3;
  localparam logic [3:0] PH_LCS     = 4'd4;
  localparam logic [3:0] PH_EXT_H   = 4'd5;
  localparam logic [3:0] PH_EXT_L   = 4'd6;
  localparam logic [3:0] PH_EXT_LCS = 4'd7;
  localparam logic [3:0] PH_SKIP    = 4'd8;
  localparam logic [3:0] PH_TFI     = 4'd9;
  localparam logic [3:0] PH_CMD     = 4'd10;
  localparam logic [3:0] PH_DATA    = 4'd11;
  localparam logic [3:0] PH_DCS     = 4'd12;
  localparam logic [3:0] PH_POST    = 4'd13;
  localparam logic [3:0] PH_IDLE    = 4'd14;

  logic [3:0]  phase_r, phase_nxt, phase_cur;
  logic [15:0] rem_r, rem_nxt, rem_cur;
  logic [7:0]  dcs_r, dcs_nxt, dcs_cur;
  logic [7:0]  len_hi_r, len_hi_nxt, len_hi_cur;
  logic [7:0]  len_lo_r, len_lo_nxt, len_lo_cur;
  logic [15:0] flen_r, flen_nxt, flen_cur;
  logic [1:0]  skip_r, skip_nxt, skip_cur;

  logic [7:0]  b;
  logic [8:0]  lcs_sum;
  logic [7:0]  ext_sum;
  logic [15:0] ext_raw;
  logic [8:0]  cmd_want;
  logic [15:0] rem_dec;
  logic        fin;
  logic [3:0]  fin_code;

  assign b        = item.rx_byte;
  assign lcs_sum  = {1'b0, len_lo_cur} + {1'b0, b};
  assign ext_sum  = len_hi_cur + len_lo_cur + b;
  assign ext_raw  = {len_hi_cur, len_lo_cur};
  assign cmd_want = {1'b0, exp_cmd} + 9'd1;
  assign rem_dec  = rem_cur - 16'd1;

  // frame_start clears the parser before the byte is taken
  always_comb begin
    if (item.frame_start) begin
      phase_cur  = PH_PRE0;
      rem_cur    = 16'd0;
      dcs_cur    = 8'd0;
      len_hi_cur = 8'd0;
      len_lo_cur = 8'd0;
      flen_cur   = 16'd0;
      skip_cur   = 2'd0;
    end else begin
      phase_cur  = phase_r;
      rem_cur    = rem_r;
      dcs_cur    = dcs_r;
      len_hi_cur = len_hi_r;
      len_lo_cur = len_lo_r;
      flen_cur   = flen_r;
      skip_cur   = skip_r;
    end
  end

  // per-byte phase logic
  always_comb begin
    phase_nxt  = phase_cur;
    rem_nxt    = rem_cur;
    dcs_nxt    = dcs_cur;
    len_hi_nxt = len_hi_cur;
    len_lo_nxt = len_lo_cur;
    flen_nxt   = flen_cur;
    skip_nxt   = skip_cur;
    fin        = 1'b0;
    fin_code   = STAT_OK;
    has_res    = 1'b0;
    res        = '0;
    case (phase_cur)
      PH_PRE0: begin
        if (b != PRE_ZERO) begin
          fin = 1'b1; fin_code = STAT_PREAMBLE;
        end else begin
          phase_nxt = PH_PRE1;
        end
      end
      PH_PRE1: begin
        if (b == PRE_START) begin
          phase_nxt = PH_LEN;
        end else if (b == PRE_ZERO) begin
          phase_nxt = PH_PRE2;
        end else begin
          fin = 1'b1; fin_code = STAT_PREAMBLE;
        end
      end
      PH_PRE2: begin
        if (b != PRE_START) begin
          fin = 1'b1; fin_code = STAT_PREAMBLE;
        end else begin
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        len_lo_nxt = b;
        phase_nxt  = PH_LCS;
      end
      PH_LCS: begin
        if (len_lo_cur == ERR_LEN && b == PRE_START) begin
          skip_nxt  = ERR_SKIP;
          phase_nxt = PH_SKIP;
        end else if (len_lo_cur == EXT_MARK && b == EXT_MARK) begin
          phase_nxt = PH_EXT_H;
        end else if (lcs_sum != LEN_CS_SUM) begin
          fin = 1'b1; fin_code = STAT_LEN_CS;
        end else if (len_lo_cur < 8'd2) begin
          flen_nxt = 16'd0;
          fin = 1'b1; fin_code = STAT_BAD_LEN;
        end else begin
          flen_nxt  = {8'd0, len_lo_cur} - 16'd2;
          phase_nxt = PH_TFI;
        end
      end
      PH_EXT_H: begin
        len_hi_nxt = b;
        phase_nxt  = PH_EXT_L;
      end
      PH_EXT_L: begin
        len_lo_nxt = b;
        phase_nxt  = PH_EXT_LCS;
      end
      PH_EXT_LCS: begin
        if (ext_sum != 8'd0) begin
          fin = 1'b1; fin_code = STAT_LEN_CS;
        end else if (ext_raw < 16'd2) begin
          flen_nxt = 16'd0;
          fin = 1'b1; fin_code = STAT_BAD_LEN;
        end else begin
          flen_nxt  = ext_raw - 16'd2;
          phase_nxt = PH_TFI;
        end
      end
      PH_SKIP: begin
        if (skip_cur <= 2'd1) begin
          skip_nxt = 2'd0;
          fin = 1'b1; fin_code = STAT_ERR_FRAME;
        end else begin
          skip_nxt = skip_cur - 2'd1;
        end
      end
      PH_TFI: begin
        if (b != DIR_BYTE) begin
          fin = 1'b1; fin_code = STAT_DIR;
        end else begin
          dcs_nxt   = b;
          phase_nxt = PH_CMD;
        end
      end
      PH_CMD: begin
        if ({1'b0, b} != cmd_want) begin
          fin = 1'b1; fin_code = STAT_CMD;
        end else begin
          dcs_nxt   = dcs_cur + b;
          rem_nxt   = flen_cur;
          phase_nxt = (flen_cur != 16'd0) ? PH_DATA : PH_DCS;
        end
      end
      PH_DATA: begin
        dcs_nxt          = dcs_cur + b;
        rem_nxt          = rem_dec;
        phase_nxt        = (rem_dec == 16'd0) ? PH_DCS : PH_DATA;
        has_res          = 1'b1;
        res.data_valid   = 1'b1;
        res.payload_byte = b;
      end
      PH_DCS: begin
        if (dcs_cur + b != 8'd0) begin
          fin = 1'b1; fin_code = STAT_DATA_CS;
        end else begin
          phase_nxt = PH_POST;
        end
      end
      PH_POST: begin
        fin = 1'b1;
        fin_code = (b == POST_BYTE) ? STAT_OK : STAT_POSTAMBLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    // frame end result
    if (fin) begin
      phase_nxt      = PH_IDLE;
      has_res        = 1'b1;
      res.frame_done = 1'b1;
      res.status     = fin_code;
    end
    res.payload_length = flen_nxt;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_PRE0;
      rem_r    <= 16'd0;
      dcs_r    <= 8'd0;
      len_hi_r <= 8'd0;
      len_lo_r <= 8'd0;
      flen_r   <= 16'd0;
      skip_r   <= 2'd0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      rem_r    <= rem_nxt;
      dcs_r    <= dcs_nxt;
      len_hi_r <= len_hi_nxt;
      len_lo_r <= len_lo_nxt;
      flen_r   <= flen_nxt;
      skip_r   <= skip_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/nfcd_out_stage.sv @@
// Result register of the deframer: holds one result request until taken.
// Depends on nfcd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nfcd_out_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           load,
  input  wire nfcd_pkg::res_t res_in,
  output logic                room,
  output logic                out_valid,
  input  wire logic           out_stall,
  output nfcd_pkg::res_t      res_out
);
  import nfcd_pkg::*;

  logic vld_r, vld_nxt;
  res_t res_r;

  // free when empty or being taken this cycle
  assign room    = !vld_r || !out_stall;
  assign vld_nxt = load || (vld_r && out_stall);

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = vld_r;
  assign res_out   = res_r;

endmodule
`default_nettype wire

@@ src/nfc_response_frame_deframer.sv @@
// NFC response frame deframer: one received byte per request in, payload
// bytes and one frame-end status per frame out.
// Path: an accepted byte is held in the input register, then parsed into the result register.
// Throughput: one byte per cycle while the result register has room, set by the single-pass parser logic.
// Reset: synchronous active-low rst_n clears both stages, the parser state
// (waiting for the first preamble byte) and expected_command to zero.
`timescale 1ns / 1ps
`default_nettype none
module nfc_response_frame_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_frame_start,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_data_valid,
  output logic [7:0]       out_payload_byte,
  output logic             out_frame_done,
  output logic [3:0]       out_status,
  output logic [15:0]      out_payload_length,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data
);
  import nfcd_pkg::*;

  logic [7:0] exp_cmd_r;
  in_item_t   in_item;
  in_item_t   item;
  logic       item_vld;
  logic       room;
  logic       step;
  logic       has_res;
  res_t       res;
  res_t       res_out;

  // expected command register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_cmd_r <= 8'd0;
    end else if (cfg_wr_en) begin
      exp_cmd_r <= cfg_wr_data;
    end
  end

  assign in_item.frame_start = in_frame_start;
  assign in_item.rx_byte     = in_rx_byte;

  // a held byte is parsed once the result register has room
  assign step = item_vld && room;

  nfcd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .pop      (step),
    .item_vld (item_vld),
    .item     (item)
  );

  nfcd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .item    (item),
    .exp_cmd (exp_cmd_r),
    .has_res (has_res),
    .res     (res)
  );

  nfcd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && has_res),
    .res_in    (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (res_out)
  );

  assign out_data_valid     = res_out.data_valid;
  assign out_payload_byte   = res_out.payload_byte;
  assign out_frame_done     = res_out.frame_done;
  assign out_status         = res_out.status;
  assign out_payload_length = res_out.payload_length;

endmodule
`default_nettype wire

@@ src/nfcd_checker.sv @@
// Port-level checker for the deframer, bound to the top level.
// Depends on nfcd_pkg and nfc_response_frame_deframer.
`timescale 1ns / 1ps
`default_nettype none
module nfcd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_data_valid,
  input wire logic [7:0]  out_payload_byte,
  input wire logic        out_frame_done,
  input wire logic [3:0]  out_status,
  input wire logic [15:0] out_payload_length
);
  import nfcd_pkg::*;

  // a stalled result request holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload_byte)
      && $stable(out_status) && $stable(out_payload_length))
    else $error("result changed while stalled");

  // every result is either a payload byte or a frame end
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data_valid ^ out_frame_done))
    else $error("result kind not exactly one");

  // payload results carry ok status
  a_data_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data_valid |-> out_status == STAT_OK)
    else $error("payload result with nonzero status");

  // frame end carries a zero byte and a known status
  a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_payload_byte == 8'd0 && out_status <= STAT_BAD_LEN)
    else $error("bad frame end fields");

  // bad length reports zero payload length
  a_bad_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done && out_status == STAT_BAD_LEN |-> out_payload_length == 16'd0)
    else $error("bad length with nonzero payload length");

endmodule

bind nfc_response_frame_deframer nfcd_checker u_nfcd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_data_valid     (out_data_valid),
  .out_payload_byte   (out_payload_byte),
  .out_frame_done     (out_frame_done),
  .out_status         (out_status),
  .out_payload_length (out_payload_length)
);
`default_nettype wire

@@ sim/tb_nfc_response_frame_deframer.sv @@
// Testbench for nfc_response_frame_deframer: random and directed response frames,
// checked result by result against a behavioral parser kept in this file.
// Depends on nfcd_pkg (status codes, frame bytes, request types) and the block itself.
`timescale 1ns / 1ps

module tb_nfc_response_frame_deframer;
  import nfcd_pkg::*;

  localparam int unsigned IDLE_PCT     = 23;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam logic [7:0]  ERR_LCS      = 8'hFF;

  // parser phases of the behavioral deframer
  typedef enum logic [3:0] {
    ST_PRE0, ST_PRE1, ST_PRE2, ST_LEN, ST_LCS, ST_XLEN_H, ST_XLEN_L, ST_XLCS,
    ST_ERR_SKIP, ST_TFI, ST_CMD, ST_DATA, ST_DCS, ST_POST, ST_DONE
  } parse_state_e;

  // ways a generated frame can be broken
  typedef enum int {
    F_NONE, F_PREAMBLE, F_LEN_CS, F_DIR, F_CMD, F_DATA_CS, F_POSTAMBLE, F_TRUNC,
    F_ERR_FRAME, F_BAD_LEN
  } fault_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_frame_start = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_data_valid;
  logic [7:0]  out_payload_byte;
  logic        out_frame_done;
  logic [3:0]  out_status;
  logic [15:0] out_payload_length;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;

  in_item_t    rx_bytes_pending[$];
  res_t        results_due[$];
  in_item_t    next_req;
  res_t        want;
  int unsigned pushed_items = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_hold = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  // shadow of the command register and parser state
  logic [7:0]   cmd_shadow = 8'h00;
  parse_state_e p_state = ST_PRE0;
  logic [15:0]  p_left = '0;
  logic [7:0]   p_dsum = '0;
  logic [7:0]   p_len_hi = '0;
  logic [7:0]   p_len_lo = '0;
  logic [15:0]  p_len = '0;
  logic [1:0]   p_skip = '0;

  nfc_response_frame_deframer DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_frame_start     (in_frame_start),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_data_valid     (out_data_valid),
    .out_payload_byte   (out_payload_byte),
    .out_frame_done     (out_frame_done),
    .out_status         (out_status),
    .out_payload_length (out_payload_length),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // frame-end result, parser then ignores bytes until the next frame start
  function automatic void close_frame(input logic [3:0] code);
    res_t r;
    r.data_valid     = 1'b0;
    r.payload_byte   = 8'h00;
    r.frame_done     = 1'b1;
    r.status         = code;
    r.payload_length = p_len;
    results_due.push_back(r);
    p_state = ST_DONE;
  endfunction

  // length field counts direction and command bytes
  function automatic void apply_length(input logic [15:0] raw);
    if (raw < 16'd2) begin
      p_len = '0;
      close_frame(STAT_BAD_LEN);
    end else begin
      p_len = raw - 16'd2;
      p_state = ST_TFI;
    end
  endfunction

  // advance the behavioral parser by one accepted byte
  function automatic void parse_rx_byte(input logic start, input logic [7:0] b);
    res_t r;
    logic [7:0] s8;
    if (start) begin
      p_state  = ST_PRE0;
      p_left   = '0;
      p_dsum   = '0;
      p_len_hi = '0;
      p_len_lo = '0;
      p_len    = '0;
      p_skip   = '0;
    end
    case (p_state)
      ST_PRE0: begin
        if (b != PRE_ZERO) close_frame(STAT_PREAMBLE);
        else p_state = ST_PRE1;
      end
      ST_PRE1: begin
        if (b == PRE_START) p_state = ST_LEN;
        else if (b == PRE_ZERO) p_state = ST_PRE2;
        else close_frame(STAT_PREAMBLE);
      end
      ST_PRE2: begin
        if (b != PRE_START) close_frame(STAT_PREAMBLE);
        else p_state = ST_LEN;
      end
      ST_LEN: begin
        p_len_lo = b;
        p_state = ST_LCS;
      end
      ST_LCS: begin
        if (p_len_lo == ERR_LEN && b == ERR_LCS) begin
          p_skip = ERR_SKIP;
          p_state = ST_ERR_SKIP;
        end else if (p_len_lo == EXT_MARK && b == EXT_MARK) begin
          p_state = ST_XLEN_H;
        end else if ({1'b0, p_len_lo} + {1'b0, b} != LEN_CS_SUM) begin
          close_frame(STAT_LEN_CS);
        end else begin
          apply_length({8'h00, p_len_lo});
        end
      end
      ST_XLEN_H: begin
        p_len_hi = b;
        p_state = ST_XLEN_L;
      end
      ST_XLEN_L: begin
        p_len_lo = b;
        p_state = ST_XLCS;
      end
      ST_XLCS: begin
        s8 = p_len_hi + p_len_lo + b;
        if (s8 != 8'h00) close_frame(STAT_LEN_CS);
        else apply_length({p_len_hi, p_len_lo});
      end
      ST_ERR_SKIP: begin
        if (p_skip <= 2'd1) begin
          p_skip = '0;
          close_frame(STAT_ERR_FRAME);
        end else begin
          p_skip = p_skip - 2'd1;
        end
      end
      ST_TFI: begin
        if (b != DIR_BYTE) begin
          close_frame(STAT_DIR);
        end else begin
          p_dsum = b;
          p_state = ST_CMD;
        end
      end
      ST_CMD: begin
        // response code is command plus one, no wrap
        if ({1'b0, b} != {1'b0, cmd_shadow} + 9'd1) begin
          close_frame(STAT_CMD);
        end else begin
          p_dsum = p_dsum + b;
          p_left = p_len;
          p_state = (p_left != 16'd0) ? ST_DATA : ST_DCS;
        end
      end
      ST_DATA: begin
        p_dsum = p_dsum + b;
        p_left = p_left - 16'd1;
        if (p_left == 16'd0) p_state = ST_DCS;
        r.data_valid     = 1'b1;
        r.payload_byte   = b;
        r.frame_done     = 1'b0;
        r.status         = STAT_OK;
        r.payload_length = p_len;
        results_due.push_back(r);
      end
      ST_DCS: begin
        s8 = p_dsum + b;
        if (s8 != 8'h00) close_frame(STAT_DATA_CS);
        else p_state = ST_POST;
      end
      ST_POST: begin
        close_frame((b == POST_BYTE) ? STAT_OK : STAT_POSTAMBLE);
      end
      default: begin
        p_state = ST_DONE;
      end
    endcase
  endfunction

  function automatic void push_byte(input logic start, input logic [7:0] b);
    in_item_t it;
    it.frame_start = start;
    it.rx_byte = b;
    rx_bytes_pending.push_back(it);
    pushed_items++;
  endfunction

  // build one response frame, optionally broken, and queue its bytes
  task automatic queue_response(input fault_e fault, input int unsigned n, input bit long_pre,
                                input bit ext, input bit lead_start);
    logic [7:0]  fb[$];
    logic [15:0] raw;
    logic [7:0]  cks;
    logic [7:0]  cmd_b;
    logic [7:0]  pb;
    int unsigned cut;
    raw = 16'(n + 2);
    fb.push_back(PRE_ZERO);
    if (long_pre) fb.push_back(PRE_ZERO);
    fb.push_back(PRE_START);
    if (fault == F_PREAMBLE) begin
      cut = $urandom_range(fb.size() - 1);
      fb[cut] = 8'($urandom_range(1, 254));
      while (fb.size() > cut + 1) void'(fb.pop_back());
    end else if (fault == F_ERR_FRAME) begin
      fb.push_back(ERR_LEN);
      fb.push_back(ERR_LCS);
      repeat (3) fb.push_back(8'($urandom_range(255)));
    end else begin
      if (fault == F_BAD_LEN) begin
        raw = 16'($urandom_range(1));
        ext = 1'b1;
      end
      // length field and its checksum
      if (ext) begin
        cks = 8'h00 - raw[15:8] - raw[7:0];
        fb.push_back(EXT_MARK);
        fb.push_back(EXT_MARK);
        fb.push_back(raw[15:8]);
        fb.push_back(raw[7:0]);
      end else begin
        cks = 8'h00 - raw[7:0];
        fb.push_back(raw[7:0]);
      end
      if (fault == F_LEN_CS) cks = cks ^ 8'($urandom_range(1, 255));
      fb.push_back(cks);
      // direction, command, payload, data checksum, postamble
      if (fault != F_LEN_CS && fault != F_BAD_LEN) begin
        cmd_b = cmd_shadow + 8'd1;
        if (fault == F_CMD) cmd_b = cmd_b ^ 8'($urandom_range(1, 255));
        fb.push_back((fault == F_DIR) ? DIR_BYTE ^ 8'($urandom_range(1, 255)) : DIR_BYTE);
        fb.push_back(cmd_b);
        cks = DIR_BYTE + cmd_b;
        repeat (n) begin
          pb = 8'($urandom_range(255));
          cks = cks + pb;
          fb.push_back(pb);
        end
        cks = 8'h00 - cks;
        if (fault == F_DATA_CS) cks = cks ^ 8'($urandom_range(1, 255));
        fb.push_back(cks);
        fb.push_back((fault == F_POSTAMBLE) ? 8'($urandom_range(1, 255)) : POST_BYTE);
      end
    end
    if (fault == F_TRUNC) begin
      cut = $urandom_range(1, fb.size() - 1);
      while (fb.size() > cut) void'(fb.pop_back());
    end
    foreach (fb[i]) push_byte((i == 0) ? lead_start : 1'b0, fb[i]);
    // stray bytes after the frame
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) push_byte(1'b0, 8'($urandom_range(255)));
    end
  endtask

  // mostly well-formed frames with random content, some broken frames and noise
  task automatic random_traffic(input int unsigned budget);
    int unsigned base;
    int unsigned r;
    int unsigned n;
    base = pushed_items;
    while (pushed_items - base < budget) begin
      r = $urandom_range(99);
      n = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(16);
      if (r < 55)
        queue_response(F_NONE, n, 1'($urandom_range(1)), $urandom_range(4) == 0, 1'b1);
      else if (r < 88)
        queue_response(fault_e'($urandom_range(F_TRUNC, F_PREAMBLE)), n,
                       1'($urandom_range(1)), $urandom_range(4) == 0, 1'b1);
      else if (r < 92)
        queue_response(F_ERR_FRAME, 0, 1'($urandom_range(1)), 1'b0, 1'b1);
      else if (r < 95)
        queue_response(F_BAD_LEN, 0, 1'($urandom_range(1)), 1'b1, 1'b1);
      else
        repeat ($urandom_range(1, 6))
          push_byte($urandom_range(99) < 30, 8'($urandom_range(255)));
    end
  endtask

  task automatic write_command(input logic [7:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    cmd_shadow = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // sender pauses here until every result is back and the pipe is empty
  task automatic wait_idle();
    do @(negedge clk);
    while (rx_bytes_pending.size() != 0 || in_valid || results_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) parse_rx_byte(in_frame_start, in_rx_byte);
      if (!in_valid || !in_stall) begin
        if (rx_bytes_pending.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          next_req = rx_bytes_pending.pop_front();
          in_valid <= 1'b1;
          in_frame_start <= next_req.frame_start;
          in_rx_byte <= next_req.rx_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_hold <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $error("unexpected result: done %0d status %0d byte %0h", out_frame_done,
                 out_status, out_payload_byte);
          fail_count = fail_count + 1;
        end else begin
          want = results_due.pop_front();
          if (out_data_valid !== want.data_valid) begin
            $error("data_valid expected %0d got %0d", want.data_valid, out_data_valid);
            fail_count = fail_count + 1;
          end
          if (out_payload_byte !== want.payload_byte) begin
            $error("payload_byte expected %0h got %0h", want.payload_byte, out_payload_byte);
            fail_count = fail_count + 1;
          end
          if (out_frame_done !== want.frame_done) begin
            $error("frame_done expected %0d got %0d", want.frame_done, out_frame_done);
            fail_count = fail_count + 1;
          end
          if (out_status !== want.status) begin
            $error("status expected %0d got %0d", want.status, out_status);
            fail_count = fail_count + 1;
          end
          if (out_payload_length !== want.payload_length) begin
            $error("payload_length expected %0d got %0d", want.payload_length,
                   out_payload_length);
            fail_count = fail_count + 1;
          end
        end
      end
      if (hold_req) rx_hold <= HOLD_CYCLES;
      else if (rx_hold != 0) rx_hold <= rx_hold - 1;
      out_stall <= hold_req || (rx_hold > 1) || (!quiet && $urandom_range(99) < IDLE_PCT);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("nfc_response_frame_deframer verification failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames with the command register at its reset value
    @(negedge clk);
    queue_response(F_NONE, 0, 1'b0, 1'b0, 1'b0);
    queue_response(F_PREAMBLE, 0, 1'b1, 1'b0, 1'b1);
    queue_response(F_ERR_FRAME, 0, 1'b0, 1'b0, 1'b1);
    queue_response(F_BAD_LEN, 0, 1'b0, 1'b1, 1'b1);
    wait_idle();

    // command FF: no response code can match
    write_command(8'hFF);
    @(negedge clk);
    random_traffic(60);
    wait_idle();

    write_command(8'h00);
    @(negedge clk);
    random_traffic(130);
    wait_idle();

    // stretch with no idling on either side
    write_command(8'hFE);
    @(negedge clk);
    quiet = 1'b1;
    random_traffic(110);
    wait_idle();
    quiet = 1'b0;

    // long receiver hold while the sender keeps offering bytes
    write_command(8'($urandom_range(255)));
    @(negedge clk);
    random_traffic(150);
    hold_req = 1'b1;
    @(negedge clk);
    hold_req = 1'b0;
    wait_idle();

    // largest normal length, one long extended frame, then more traffic
    write_command(8'($urandom_range(255)));
    @(negedge clk);
    queue_response(F_NONE, 253, 1'b0, 1'b0, 1'b1);
    queue_response(F_NONE, 300, 1'b1, 1'b1, 1'b1);
    random_traffic(80);
    wait_idle();

    if (fail_count == 0) begin
      $display("nfc_response_frame_deframer verification clean");
    end else begin
      $display("nfc_response_frame_deframer verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/nfcd_pkg.sv
src/nfcd_in_stage.sv
src/nfcd_parser.sv
src/nfcd_out_stage.sv
src/nfc_response_frame_deframer.sv
src/nfcd_checker.sv
sim/tb_nfc_response_frame_deframer.sv
